FILE: hdl/vrrq_pkg.sv
`default_nettype none
package vrrq_pkg;

    localparam int RING_BYTES   = 4096;
    localparam int HEADER_BYTES = 8;

    localparam int ADDR_W = $clog2(RING_BYTES);
    localparam int SIZE_W = ADDR_W + 1;
    localparam int CALC_W = SIZE_W + 1;
    localparam int HIDX_W = $clog2(HEADER_BYTES);
    localparam int LEN_W  = 12;
    localparam int CFG_SIZE_W = 13;
    localparam int MIN_RING = 3 * HEADER_BYTES;

    typedef enum logic [1:0] {
        KIND_SEND_START = 2'd0,
        KIND_SEND_BYTE  = 2'd1,
        KIND_RECV_START = 2'd2,
        KIND_RECV_BYTE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_REJECTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_MISMATCH = 3'd4,
        ST_SEQ_ERR  = 3'd5
    } status_t;

    typedef enum logic {
        REG_RING_SIZE   = 1'b0,
        REG_MARKER_TYPE = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        CONS_NONE,
        CONS_TAIL,
        CONS_HDR,
        CONS_REC,
        CONS_ONE
    } cons_t;

    typedef enum logic [1:0] {
        WR_MARK,
        WR_HDR,
        WR_DATA
    } wsel_t;

    typedef enum logic [1:0] {
        RSP_PLAIN,
        RSP_ACCEPT,
        RSP_BYTE
    } rsp_t;

    typedef struct packed {
        logic    capture;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    we;
        wsel_t   wsel;
        logic    rd_hdr;
        logic    rd_byte;
        logic    tries_clr;
        logic    tries_inc;
        cons_t   cons;
        logic    commit_send;
        logic    send_upd;
        logic    recv_accept;
        logic    recv_upd;
        logic    respond;
        rsp_t    rsp;
        status_t status;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  send_open;
        logic  recv_open;
        logic  reject;
        logic  full;
        logic  mark_needed;
        logic  cnt_last;
        logic  tries_done;
        logic  committed_zero;
        logic  tail_short;
        logic  is_marker;
        logic  rec_over;
        logic  type_match;
    } stat_t;

    // byte idx of a header: type LE, then length LE, then zero
    function automatic logic [7:0] hdr_byte(input logic [31:0] t, input logic [31:0] l,
                                            input logic [HIDX_W-1:0] idx);
        logic [7:0] b;
        b = 8'd0;
        if (idx < HIDX_W'(4))
            b = t[8*idx[1:0] +: 8];
        else if (32'(idx) < 32'd8)
            b = l[8*idx[1:0] +: 8];
        return b;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/vrrq_ctrl.sv
`default_nettype none
module vrrq_ctrl
    import vrrq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MARK,
        S_HDR,
        S_RTRY,
        S_RHDR,
        S_RWAIT,
        S_RCHK,
        S_BWAIT
    } state_t;

    state_t state_reg, state_next;

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        cmd.cons   = CONS_NONE;
        cmd.wsel   = WR_DATA;
        cmd.rsp    = RSP_PLAIN;
        cmd.status = ST_OK;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.kind)
                    KIND_SEND_START:
                    begin
                        priority if (stat.send_open)
                        begin
                            cmd.respond = 1'b1;
                            cmd.status  = ST_SEQ_ERR;
                            state_next  = S_IDLE;
                        end
                        else if (stat.reject)
                        begin
                            cmd.respond = 1'b1;
                            cmd.status  = ST_REJECTED;
                            state_next  = S_IDLE;
                        end
                        else if (stat.full)
                        begin
                            cmd.respond = 1'b1;
                            cmd.status  = ST_FULL;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            cmd.cnt_clr = 1'b1;
                            state_next  = stat.mark_needed ? S_MARK : S_HDR;
                        end
                    end
                    KIND_SEND_BYTE:
                    begin
                        cmd.respond = 1'b1;
                        state_next  = S_IDLE;
                        if (!stat.send_open)
                            cmd.status = ST_SEQ_ERR;
                        else
                        begin
                            cmd.we       = 1'b1;
                            cmd.wsel     = WR_DATA;
                            cmd.send_upd = 1'b1;
                        end
                    end
                    KIND_RECV_START:
                    begin
                        if (stat.recv_open)
                        begin
                            cmd.respond = 1'b1;
                            cmd.status  = ST_SEQ_ERR;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            cmd.tries_clr = 1'b1;
                            state_next    = S_RTRY;
                        end
                    end
                    KIND_RECV_BYTE:
                    begin
                        if (!stat.recv_open)
                        begin
                            cmd.respond = 1'b1;
                            cmd.status  = ST_SEQ_ERR;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            cmd.rd_byte = 1'b1;
                            state_next  = S_BWAIT;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_MARK:
            begin
                cmd.we   = 1'b1;
                cmd.wsel = WR_MARK;
                if (stat.cnt_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_HDR;
                end
                else
                    cmd.cnt_inc = 1'b1;
            end
            S_HDR:
            begin
                cmd.we      = 1'b1;
                cmd.wsel    = WR_HDR;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_last)
                begin
                    cmd.commit_send = 1'b1;
                    cmd.respond     = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_RTRY:
            begin
                priority if (stat.tries_done || stat.committed_zero)
                begin
                    cmd.respond = 1'b1;
                    cmd.status  = ST_EMPTY;
                    state_next  = S_IDLE;
                end
                else if (stat.tail_short)
                begin
                    cmd.cons      = CONS_TAIL;
                    cmd.tries_inc = 1'b1;
                end
                else
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_RHDR;
                end
            end
            S_RHDR:
            begin
                cmd.rd_hdr  = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_last)
                    state_next = S_RWAIT;
            end
            S_RWAIT:
                state_next = S_RCHK;
            S_RCHK:
            begin
                priority if (stat.is_marker)
                begin
                    cmd.cons      = CONS_TAIL;
                    cmd.tries_inc = 1'b1;
                    state_next    = S_RTRY;
                end
                else if (stat.rec_over)
                begin
                    cmd.respond = 1'b1;
                    cmd.status  = ST_EMPTY;
                    state_next  = S_IDLE;
                end
                else if (stat.type_match)
                begin
                    cmd.recv_accept = 1'b1;
                    cmd.cons        = CONS_HDR;
                    cmd.respond     = 1'b1;
                    cmd.rsp         = RSP_ACCEPT;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.cons    = CONS_REC;
                    cmd.respond = 1'b1;
                    cmd.status  = ST_MISMATCH;
                    state_next  = S_IDLE;
                end
            end
            S_BWAIT:
            begin
                cmd.recv_upd = 1'b1;
                cmd.cons     = CONS_ONE;
                cmd.respond  = 1'b1;
                cmd.rsp      = RSP_BYTE;
                state_next   = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/vrrq_dp.sv
`default_nettype none
module vrrq_dp
    import vrrq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    output stat_t            stat,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] msg_type,
    input  wire logic [LEN_W-1:0] msg_length,
    input  wire logic [7:0]  data_byte,
    input  wire logic [31:0] wanted_type,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             done,
    output logic [2:0]       status,
    output logic [31:0]      out_type,
    output logic [LEN_W-1:0] out_length,
    output logic [7:0]       out_byte,
    output logic             out_last
);

    logic [7:0] ring_mem [RING_BYTES];
    logic [7:0] rdata_reg;

    logic [SIZE_W-1:0] ring_size_reg;
    logic [31:0]       marker_reg;
    logic [ADDR_W-1:0] rsv_pos_reg, rsv_pos_next;
    logic [ADDR_W-1:0] rd_pos_reg, rd_pos_next;
    logic [SIZE_W-1:0] reserved_reg, reserved_next;
    logic [SIZE_W-1:0] committed_reg, committed_next;
    logic [SIZE_W-1:0] send_left_reg, recv_left_reg;
    logic              send_open_reg, recv_open_reg;

    kind_t             kind_reg;
    logic [31:0]       type_reg, want_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [7:0]        byte_reg;
    logic [HIDX_W-1:0] cnt_reg;
    logic [1:0]        tries_reg;
    logic              hdr_pend_reg;
    logic [HIDX_W-1:0] hdr_idx_reg;
    logic [7:0]        hdr_reg [HEADER_BYTES];

    logic              done_reg;
    logic [2:0]        status_reg;
    logic [31:0]       out_type_reg;
    logic [LEN_W-1:0]  out_length_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;

    // send side arithmetic
    logic [CALC_W-1:0] s_w, rec_w, pos_w, tail_w, pad_w, nr_w, wp_w, dat_w;
    logic              wrap;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;

    // receive side arithmetic
    logic [31:0]       htype, hlen;
    logic [CALC_W-1:0] rtail_w, cons_n, csum_w;
    logic [32:0]       hrec;

    logic [CFG_SIZE_W-1:0] cfg_size;
    logic [SIZE_W-1:0]     cfg_size_clamped;

    always_comb
    begin
        s_w    = CALC_W'(ring_size_reg);
        rec_w  = CALC_W'(HEADER_BYTES) + CALC_W'(len_reg);
        pos_w  = CALC_W'(rsv_pos_reg);
        tail_w = s_w - pos_w;
        wrap   = (pos_w + rec_w) > s_w;
        pad_w  = wrap ? tail_w : '0;
        wp_w   = wrap ? '0 : pos_w;
        nr_w   = wp_w + rec_w;
        if (nr_w >= s_w)
            nr_w = nr_w - s_w;
        dat_w  = pos_w + s_w - CALC_W'(send_left_reg);
        if (dat_w >= s_w)
            dat_w = dat_w - s_w;

        unique case (cmd.wsel)
            WR_MARK:
            begin
                waddr = rsv_pos_reg + ADDR_W'(cnt_reg);
                wdata = hdr_byte(marker_reg, 32'd0, cnt_reg);
            end
            WR_HDR:
            begin
                waddr = wp_w[ADDR_W-1:0] + ADDR_W'(cnt_reg);
                wdata = hdr_byte(type_reg, 32'(len_reg), cnt_reg);
            end
            default:
            begin
                waddr = dat_w[ADDR_W-1:0];
                wdata = byte_reg;
            end
        endcase
    end

    always_comb
    begin
        htype   = {hdr_reg[3], hdr_reg[2], hdr_reg[1], hdr_reg[0]};
        hlen    = {hdr_reg[7], hdr_reg[6], hdr_reg[5], hdr_reg[4]};
        hrec    = 33'(hlen) + 33'(HEADER_BYTES);
        rtail_w = s_w - CALC_W'(rd_pos_reg);
        unique case (cmd.cons)
            CONS_TAIL: cons_n = rtail_w;
            CONS_HDR:  cons_n = CALC_W'(HEADER_BYTES);
            CONS_REC:  cons_n = hrec[CALC_W-1:0];
            CONS_ONE:  cons_n = CALC_W'(1);
            default:   cons_n = '0;
        endcase
        csum_w = CALC_W'(rd_pos_reg) + cons_n;
        if (csum_w >= s_w)
            csum_w = csum_w - s_w;
        rd_pos_next    = csum_w[ADDR_W-1:0];
        committed_next = (CALC_W'(committed_reg) >= cons_n) ?
                         committed_reg - cons_n[SIZE_W-1:0] : '0;
        reserved_next  = (CALC_W'(reserved_reg) >= cons_n) ?
                         reserved_reg - cons_n[SIZE_W-1:0] : '0;
        rsv_pos_next   = nr_w[ADDR_W-1:0];
    end

    always_comb
    begin
        cfg_size = cfg_data[CFG_SIZE_W-1:0];
        if (32'(cfg_size) < 32'(MIN_RING))
            cfg_size_clamped = SIZE_W'(MIN_RING);
        else if (32'(cfg_size) > 32'(RING_BYTES))
            cfg_size_clamped = SIZE_W'(RING_BYTES);
        else
            cfg_size_clamped = SIZE_W'(cfg_size);
    end

    always_comb
    begin
        stat.kind           = kind_reg;
        stat.send_open      = send_open_reg;
        stat.recv_open      = recv_open_reg;
        stat.reject         = (type_reg == marker_reg) ||
                              (rec_w > s_w - CALC_W'(HEADER_BYTES));
        stat.full           = (CALC_W'(reserved_reg) + pad_w + rec_w) > s_w;
        stat.mark_needed    = wrap && (tail_w >= CALC_W'(HEADER_BYTES));
        stat.cnt_last       = (cnt_reg == HIDX_W'(HEADER_BYTES - 1));
        stat.tries_done     = (tries_reg == 2'd3);
        stat.committed_zero = (committed_reg == '0);
        stat.tail_short     = rtail_w < CALC_W'(HEADER_BYTES);
        stat.is_marker      = (htype == marker_reg) && (hlen == 32'd0);
        stat.rec_over       = hrec > 33'(committed_reg);
        stat.type_match     = (htype == want_reg);
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.we)
            ring_mem[waddr] <= wdata;
        if (cmd.rd_hdr)
            rdata_reg <= ring_mem[rd_pos_reg + ADDR_W'(cnt_reg)];
        else if (cmd.rd_byte)
            rdata_reg <= ring_mem[rd_pos_reg];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind_t'(kind);
            type_reg <= msg_type;
            len_reg  <= msg_length;
            byte_reg <= data_byte;
            want_reg <= wanted_type;
        end
        if (hdr_pend_reg)
            hdr_reg[hdr_idx_reg] <= rdata_reg;
        hdr_idx_reg <= cnt_reg;
        if (cmd.respond)
        begin
            status_reg     <= cmd.status;
            out_type_reg   <= (cmd.rsp == RSP_ACCEPT) ? htype : 32'd0;
            out_length_reg <= (cmd.rsp == RSP_ACCEPT) ? hlen[LEN_W-1:0] : '0;
            out_byte_reg   <= (cmd.rsp == RSP_BYTE) ? rdata_reg : 8'd0;
            out_last_reg   <= (cmd.rsp == RSP_BYTE) && (recv_left_reg == SIZE_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg <= SIZE_W'(RING_BYTES);
            marker_reg    <= 32'hFFFF_FFFF;
            rsv_pos_reg   <= '0;
            rd_pos_reg    <= '0;
            reserved_reg  <= '0;
            committed_reg <= '0;
            send_left_reg <= '0;
            recv_left_reg <= '0;
            send_open_reg <= 1'b0;
            recv_open_reg <= 1'b0;
            cnt_reg       <= '0;
            tries_reg     <= '0;
            hdr_pend_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg     <= cmd.respond;
            hdr_pend_reg <= cmd.rd_hdr;
            if (cmd.cnt_clr)
                cnt_reg <= '0;
            else if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.tries_clr)
                tries_reg <= '0;
            else if (cmd.tries_inc)
                tries_reg <= tries_reg + 1'b1;

            if (cmd.cons != CONS_NONE)
            begin
                rd_pos_reg    <= rd_pos_next;
                committed_reg <= committed_next;
                reserved_reg  <= reserved_next;
            end

            if (cmd.commit_send)
            begin
                reserved_reg <= reserved_reg + pad_w[SIZE_W-1:0] + rec_w[SIZE_W-1:0];
                rsv_pos_reg  <= rsv_pos_next;
                if (len_reg == '0)
                    committed_reg <= reserved_reg + pad_w[SIZE_W-1:0] + rec_w[SIZE_W-1:0];
                else
                begin
                    send_open_reg <= 1'b1;
                    send_left_reg <= SIZE_W'(len_reg);
                end
            end

            if (cmd.send_upd)
            begin
                send_left_reg <= send_left_reg - 1'b1;
                if (send_left_reg == SIZE_W'(1))
                begin
                    send_open_reg <= 1'b0;
                    committed_reg <= reserved_reg;
                end
            end

            if (cmd.recv_accept)
            begin
                recv_left_reg <= hlen[SIZE_W-1:0];
                recv_open_reg <= (hlen != 32'd0);
            end

            if (cmd.recv_upd)
            begin
                recv_left_reg <= recv_left_reg - 1'b1;
                if (recv_left_reg == SIZE_W'(1))
                    recv_open_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_RING_SIZE:
                    begin
                        ring_size_reg <= cfg_size_clamped;
                        rsv_pos_reg   <= '0;
                        rd_pos_reg    <= '0;
                        reserved_reg  <= '0;
                        committed_reg <= '0;
                        send_left_reg <= '0;
                        recv_left_reg <= '0;
                        send_open_reg <= 1'b0;
                        recv_open_reg <= 1'b0;
                    end
                    REG_MARKER_TYPE: marker_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign out_type   = out_type_reg;
    assign out_length = out_length_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;

endmodule
`default_nettype wire

FILE: hdl/variable_record_ring_queue_core.sv
// Each item is captured on start, then decoded; a send byte and any refused item are
// answered from decode, a receive byte after its registered ring read. A send start
// writes marker and header a byte a cycle; a receive start reads headers a byte a cycle.
// One item at a time: busy stays high until the item's response is registered.
// Reset clears all pointers and counts at once; ring contents are not cleared.
// The done strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none
module variable_record_ring_queue_core
    import vrrq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] msg_type,
    input  wire logic [11:0] msg_length,
    input  wire logic [7:0]  data_byte,
    input  wire logic [31:0] wanted_type,
    output logic             done,
    output logic [2:0]       status,
    output logic [31:0]      out_type,
    output logic [11:0]      out_length,
    output logic [7:0]       out_byte,
    output logic             out_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = ~busy;

    vrrq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    vrrq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .kind         (kind),
        .msg_type     (msg_type),
        .msg_length   (msg_length),
        .data_byte    (data_byte),
        .wanted_type  (wanted_type),
        .cfg_we       (cfg_valid & cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .status       (status),
        .out_type     (out_type),
        .out_length   (out_length),
        .out_byte     (out_byte),
        .out_last     (out_last)
    );

endmodule
`default_nettype wire

FILE: dv/vrrq_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module vrrq_checker
    import vrrq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] msg_type,
    input  wire logic [11:0] msg_length,
    input  wire logic [7:0]  data_byte,
    input  wire logic [31:0] wanted_type,
    input  wire logic        done,
    input  wire logic [2:0]  status,
    input  wire logic [31:0] out_type,
    input  wire logic [11:0] out_length,
    input  wire logic [7:0]  out_byte,
    input  wire logic        out_last,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               errors,
    output int               pending,
    output logic             q_send_open,
    output logic             q_recv_open,
    output int               q_ring_size
);

    typedef struct packed {
        status_t     st;
        logic [31:0] rtype;
        logic [11:0] rlen;
        logic [7:0]  rbyte;
        logic        rlast;
    } answer_t;

    answer_t expected_answers[$];

    logic [7:0]  ring_mem [RING_BYTES];
    int unsigned reserve_pos;
    int unsigned read_pos;
    int unsigned reserved_cnt;
    int unsigned committed_cnt;
    int unsigned send_left;
    int unsigned recv_left;
    int unsigned ring_len;
    logic [31:0] marker;
    logic        s_open;
    logic        r_open;

    initial
    begin
        errors = 0;
        foreach (ring_mem[i]) ring_mem[i] = 8'd0;
    end

    function automatic void put_b(int unsigned a, logic [7:0] v);
        if (a < RING_BYTES) ring_mem[a] = v;
    endfunction

    function automatic logic [31:0] get_w(int unsigned a);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < 4; i++)
            if (a + i < RING_BYTES) v[8*i +: 8] = ring_mem[a + i];
        return v;
    endfunction

    function automatic void put_hdr(int unsigned a, logic [31:0] t, logic [31:0] l);
        for (int i = 0; i < 4; i++)
        begin
            put_b(a + i, t[8*i +: 8]);
            put_b(a + 4 + i, l[8*i +: 8]);
        end
        for (int i = 8; i < HEADER_BYTES; i++) put_b(a + i, 8'd0);
    endfunction

    function automatic void empty_queue();
        reserve_pos = 0; read_pos = 0; reserved_cnt = 0; committed_cnt = 0;
        send_left = 0; recv_left = 0; s_open = 0; r_open = 0;
    endfunction

    function automatic void consume(int unsigned n);
        read_pos = (read_pos + n) % ring_len;
        committed_cnt = committed_cnt >= n ? committed_cnt - n : 0;
        reserved_cnt = reserved_cnt >= n ? reserved_cnt - n : 0;
    endfunction

    function automatic answer_t predict_queue_answer(kind_t k, logic [31:0] t,
                                                     logic [11:0] l, logic [7:0] d,
                                                     logic [31:0] want);
        answer_t a;
        int unsigned rec, pos, tail, pad, wp;
        logic wrap;
        logic [31:0] htype, hlen;
        longint unsigned hrec;
        a = '0;
        a.st = ST_OK;
        case (k)
            KIND_SEND_START:
            begin
                rec = HEADER_BYTES + l;
                if (s_open)
                    a.st = ST_SEQ_ERR;
                else if (t == marker || rec > ring_len - HEADER_BYTES)
                    a.st = ST_REJECTED;
                else
                begin
                    pos = reserve_pos;
                    tail = ring_len - pos;
                    wrap = pos + rec > ring_len;
                    pad = wrap ? tail : 0;
                    if (reserved_cnt + pad + rec > ring_len)
                        a.st = ST_FULL;
                    else
                    begin
                        wp = wrap ? 0 : pos;
                        if (wrap && tail >= HEADER_BYTES) put_hdr(pos, marker, 0);
                        put_hdr(wp, t, 32'(l));
                        reserved_cnt += pad + rec;
                        reserve_pos = (wp + rec) % ring_len;
                        if (l == 0)
                            committed_cnt = reserved_cnt;
                        else
                        begin
                            s_open = 1;
                            send_left = l;
                        end
                    end
                end
            end
            KIND_SEND_BYTE:
            begin
                if (!s_open)
                    a.st = ST_SEQ_ERR;
                else
                begin
                    put_b((reserve_pos + ring_len - send_left) % ring_len, d);
                    send_left--;
                    if (send_left == 0)
                    begin
                        s_open = 0;
                        committed_cnt = reserved_cnt;
                    end
                end
            end
            KIND_RECV_START:
            begin
                if (r_open)
                    a.st = ST_SEQ_ERR;
                else
                begin
                    a.st = ST_EMPTY;
                    for (int tries = 0; tries < 3; tries++)
                    begin
                        pos = read_pos;
                        tail = ring_len - pos;
                        if (committed_cnt == 0) break;
                        // short tail gap or marker: skip to ring start
                        if (tail < HEADER_BYTES)
                        begin
                            consume(tail);
                            continue;
                        end
                        htype = get_w(pos);
                        hlen = get_w(pos + 4);
                        if (htype == marker && hlen == 0)
                        begin
                            consume(tail);
                            continue;
                        end
                        hrec = longint'(HEADER_BYTES) + hlen;
                        if (hrec > committed_cnt) break;
                        if (htype == want)
                        begin
                            a.st = ST_OK;
                            a.rtype = htype;
                            a.rlen = hlen[11:0];
                            consume(HEADER_BYTES);
                            recv_left = hlen;
                            r_open = hlen != 0;
                        end
                        else
                        begin
                            a.st = ST_MISMATCH;
                            consume(int'(hrec));
                        end
                        break;
                    end
                end
            end
            default:
            begin
                if (!r_open)
                    a.st = ST_SEQ_ERR;
                else
                begin
                    a.rbyte = (read_pos < RING_BYTES) ? ring_mem[read_pos] : 8'd0;
                    consume(1);
                    recv_left--;
                    if (recv_left == 0)
                    begin
                        r_open = 0;
                        a.rlast = 1;
                    end
                end
            end
        endcase
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t e;
        int unsigned s;
        if (!rst_n)
        begin
            empty_queue();
            ring_len = RING_BYTES < 4096 ? RING_BYTES : 4096;
            marker = 32'hFFFF_FFFF;
            expected_answers.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_answers.size() == 0)
                begin
                    $error("result with nothing expected: status %0d", status);
                    errors++;
                end
                else
                begin
                    e = expected_answers.pop_front();
                    if (status != e.st)
                    begin
                        $error("status: expected %0d, got %0d", e.st, status);
                        errors++;
                    end
                    if (out_type != e.rtype)
                    begin
                        $error("out_type: expected %h, got %h", e.rtype, out_type);
                        errors++;
                    end
                    if (out_length != e.rlen)
                    begin
                        $error("out_length: expected %0d, got %0d", e.rlen, out_length);
                        errors++;
                    end
                    if (out_byte != e.rbyte)
                    begin
                        $error("out_byte: expected %h, got %h", e.rbyte, out_byte);
                        errors++;
                    end
                    if (out_last != e.rlast)
                    begin
                        $error("out_last: expected %0d, got %0d", e.rlast, out_last);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_RING_SIZE)
                begin
                    s = cfg_data & 32'h1FFF;
                    if (s < MIN_RING) s = MIN_RING;
                    if (s > RING_BYTES) s = RING_BYTES;
                    ring_len = s;
                    empty_queue();
                end
                else
                    marker = cfg_data;
            end
            if (start && !busy)
                expected_answers.push_back(predict_queue_answer(kind_t'(kind), msg_type,
                                           msg_length, data_byte, wanted_type));
        end
        pending = expected_answers.size();
        q_send_open = s_open;
        q_recv_open = r_open;
        q_ring_size = ring_len;
    end

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import vrrq_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [31:0] msg_type;
    logic [11:0] msg_length;
    logic [7:0]  data_byte;
    logic [31:0] wanted_type;
    logic        done;
    logic [2:0]  status;
    logic [31:0] out_type;
    logic [11:0] out_length;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    int          errors;
    int          pending;
    logic        m_send_open;
    logic        m_recv_open;
    int          m_ring_size;
    int          quiet_cycles;
    logic        no_idle;
    logic [31:0] cur_marker;
    logic [31:0] old_marker;

    variable_record_ring_queue_core i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .msg_type(msg_type), .msg_length(msg_length), .data_byte(data_byte),
        .wanted_type(wanted_type), .done(done), .status(status),
        .out_type(out_type), .out_length(out_length), .out_byte(out_byte),
        .out_last(out_last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    vrrq_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .msg_type(msg_type), .msg_length(msg_length), .data_byte(data_byte),
        .wanted_type(wanted_type), .done(done), .status(status),
        .out_type(out_type), .out_length(out_length), .out_byte(out_byte),
        .out_last(out_last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors),
        .pending(pending), .q_send_open(m_send_open), .q_recv_open(m_recv_open),
        .q_ring_size(m_ring_size)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= 20000)
        begin
            $display("testbench: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic issue(kind_t k, logic [31:0] t, logic [11:0] l, logic [7:0] d,
                         logic [31:0] w);
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < 31)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        start <= 1'b1;
        kind <= k;
        msg_type <= t;
        msg_length <= l;
        data_byte <= d;
        wanted_type <= w;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_MARKER_TYPE)
        begin
            old_marker = cur_marker;
            cur_marker = v;
        end
    endtask

    function automatic logic [31:0] pick_type();
        case ($urandom_range(0, 5))
            0: return 32'd1;
            1: return 32'd2;
            2: return 32'd3;
            3: return cur_marker;
            4: return old_marker;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [11:0] pick_length();
        int r;
        int cap;
        r = $urandom_range(0, 99);
        cap = m_ring_size < 56 ? m_ring_size - 16 : 40;
        if (r < 70) return 12'($urandom_range(0, cap));
        if (r < 90) return 12'($urandom_range(0, m_ring_size <= 256 ? m_ring_size : 300));
        return 12'($urandom);
    endfunction

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (m_send_open && r < 60)
            issue(KIND_SEND_BYTE, $urandom, 0, 8'($urandom), $urandom);
        else if (m_recv_open && r < 85)
            issue(KIND_RECV_BYTE, $urandom, 0, 8'($urandom), $urandom);
        else if (r < 91)
        begin
            if ($urandom_range(0, 1))
                issue(KIND_SEND_START, pick_type(), pick_length(), 8'($urandom), $urandom);
            else
                issue(KIND_RECV_START, $urandom, 0, 8'($urandom), pick_type());
        end
        else
            issue(kind_t'($urandom_range(0, 3)), pick_type(), 12'($urandom),
                  8'($urandom), pick_type());
    endtask

    initial
    begin
        int          sizes [6];
        logic [31:0] marks [6];
        rst_n = 1'b0;
        start = 1'b0;
        kind = KIND_SEND_START;
        msg_type = '0;
        msg_length = '0;
        data_byte = '0;
        wanted_type = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_RING_SIZE;
        cfg_data = '0;
        no_idle = 1'b0;
        cur_marker = 32'hFFFF_FFFF;
        old_marker = 32'hFFFF_FFFF;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: errors on an empty queue, rejects, then a short exchange
        issue(KIND_RECV_START, 0, 0, 0, 32'd1);
        issue(KIND_RECV_BYTE, 0, 0, 0, 0);
        issue(KIND_SEND_BYTE, 0, 0, 8'hFF, 0);
        issue(KIND_SEND_START, 32'hFFFF_FFFF, 12'd4, 0, 0);
        issue(KIND_SEND_START, 32'd9, 12'd4095, 0, 0);
        issue(KIND_SEND_START, 32'd0, 12'd0, 0, 0);
        issue(KIND_RECV_START, 0, 0, 0, 32'd0);
        issue(KIND_SEND_START, 32'd5, 12'd2, 0, 0);
        issue(KIND_SEND_BYTE, 0, 0, 8'hAA, 0);
        issue(KIND_SEND_START, 32'd6, 12'd1, 0, 0);
        issue(KIND_RECV_START, 0, 0, 0, 32'd5);
        issue(KIND_SEND_BYTE, 0, 0, 8'h55, 0);
        issue(KIND_SEND_START, 32'd6, 12'd1, 0, 0);
        issue(KIND_SEND_BYTE, 0, 0, 8'h00, 0);
        issue(KIND_RECV_START, 0, 0, 0, 32'd5);
        issue(KIND_RECV_START, 0, 0, 0, 32'd5);
        issue(KIND_RECV_BYTE, 0, 0, 0, 0);
        issue(KIND_RECV_BYTE, 0, 0, 0, 0);
        issue(KIND_RECV_START, 0, 0, 0, 32'hFFFF_FFFF);
        issue(KIND_RECV_START, 0, 0, 0, 32'd6);

        // largest record a 64-byte ring takes
        write_reg(REG_RING_SIZE, 32'd64);
        issue(KIND_SEND_START, 32'hFFFF_FFFE, 12'd48, 0, 0);
        for (int i = 0; i < 48; i++) issue(KIND_SEND_BYTE, 0, 0, 8'($urandom), 0);
        issue(KIND_RECV_START, 0, 0, 0, 32'hFFFF_FFFE);
        issue(KIND_RECV_START, 0, 0, 0, 32'hFFFF_FFFE);
        for (int i = 0; i < 48; i++) issue(KIND_RECV_BYTE, 0, 0, 0, 0);

        sizes = '{24, 5, 8191, 37, 100, 4096};
        marks = '{32'd0, 32'hFFFF_FFFF, 32'd7, $urandom, 32'hA5A5_A5A5, 32'hFFFF_FFFF};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_RING_SIZE, sizes[p]);
            no_idle = (p == 2);
            for (int i = 0; i < 120; i++)
            begin
                // marker change with records still queued
                if (i == 60) write_reg(REG_MARKER_TYPE, marks[p]);
                if (p == 1 && i == 40) drain();
                random_item();
            end
        end

        start <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
hdl/vrrq_pkg.sv
hdl/vrrq_ctrl.sv
hdl/vrrq_dp.sv
hdl/variable_record_ring_queue_core.sv
dv/vrrq_checker.sv
dv/testbench.sv
